[rtl/sksol_pkg.sv]
// ----------------------------------------------------------------------------
// Station keeping solution package
// Shared widths, constants, pipeline word types and a helper function.
// ----------------------------------------------------------------------------
package sksol_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int XY_W = 48;
   localparam int Z_W = 34;
   localparam int MAG_W = 44;
   localparam int NUM_W = 60;
   localparam int QUO_W = 40;
   localparam int CMP_W = 72;

   localparam logic [15:0] TURN = 16'd36000;
   localparam logic [31:0] GAIN = 32'd2608131496;
   // Reciprocal of 1125 scaled by 2^40, truncated.
   localparam logic [29:0] RECIP_1125 = 30'd977343669;
   localparam logic OP_SPEED = 1'b0;
   localparam logic OP_DURATION = 1'b1;

   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   typedef struct packed {
      logic               valid;
      logic               bad;
      logic               op;
      logic               neg;
      logic [15:0]        ocrs;
      logic [31:0]        given;
      logic signed [32:0] dn_base;
      logic signed [32:0] de_base;
   } tag_type;

   typedef struct packed {
      logic        valid;
      logic        bad;
      logic        onst;
      logic        op;
      logic        ovf;
      logic [15:0] ocrs;
      logic [15:0] crs;
      logic [33:0] trange;
      logic [31:0] given;
   } dtag_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [31:0]      den;
      logic [QUO_W-1:0] quo;
   } div_type;

   function automatic logic [15:0] mod_turn(input logic [15:0] v);
      mod_turn = (v >= TURN) ? 16'(v - TURN) : v;
   endfunction

endpackage

[rtl/station_keeping_solution_core.sv]
// ----------------------------------------------------------------------------
// Station keeping solution core
// Finds course, distance and time or speed from own ship to a station point.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy is always low.
// The pipeline holds the two CORDIC chains and the 40-cell divider chain.
// Reset clears every stage valid bit; words in flight are dropped.
// The receiver cannot stall, so each result shows for exactly one cycle.
module station_keeping_solution_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_own_x,
   input  logic [31:0] req_own_y,
   input  logic [15:0] req_own_course,
   input  logic [31:0] req_guide_x,
   input  logic [31:0] req_guide_y,
   input  logic [15:0] req_guide_course,
   input  logic [15:0] req_relative_bearing,
   input  logic [31:0] req_station_range,
   input  logic        req_operation,
   input  logic [31:0] req_given_value,
   output logic        rsp_strobe,
   output logic [15:0] rsp_course_to_station,
   output logic [33:0] rsp_transit_range,
   output logic [39:0] rsp_transit_seconds,
   output logic [31:0] rsp_required_speed,
   output logic        rsp_on_station,
   output logic        rsp_bad_value
);

   localparam int N = sksol_pkg::CORDIC_STEPS;
   localparam int QW = sksol_pkg::QUO_W;

   assign busy = 1'b0;

   // Stage A: reduce angles, form station azimuth and position differences.
   sksol_pkg::tag_type a_tag_ff, a_tag_in;
   logic [15:0] a_az_ff, a_az_in;
   logic [31:0] a_rng_ff;
   logic [16:0] a_sum;

   always_comb begin
      a_sum = 17'(sksol_pkg::mod_turn(req_guide_course))
            + 17'(sksol_pkg::mod_turn(req_relative_bearing));
      a_az_in = (a_sum >= 17'(sksol_pkg::TURN)) ? 16'(a_sum - 17'(sksol_pkg::TURN))
                                                 : a_sum[15:0];
      a_tag_in.valid = start & ~busy;
      a_tag_in.bad = (req_given_value == 32'd0);
      a_tag_in.op = req_operation;
      a_tag_in.neg = 1'b0;
      a_tag_in.ocrs = sksol_pkg::mod_turn(req_own_course);
      a_tag_in.given = req_given_value;
      a_tag_in.dn_base = $signed({req_guide_y[31], req_guide_y})
                       - $signed({req_own_y[31], req_own_y});
      a_tag_in.de_base = $signed({req_guide_x[31], req_guide_x})
                       - $signed({req_own_x[31], req_own_x});
   end

   always_ff @(posedge clock) begin
      a_az_ff <= a_az_in;
      a_rng_ff <= req_station_range;
      if (reset) begin
         a_tag_ff.valid <= 1'b0;
      end else begin
         a_tag_ff <= a_tag_in;
      end
   end

   // Stage B: azimuth to binary angle, split as az*119304 + (az*23296+18000)/36000.
   sksol_pkg::tag_type b_tag_ff;
   logic [29:0] b_t;
   logic [54:0] b_prod;
   logic [14:0] b_q0_ff;
   logic [24:0] b_u_ff;
   logic [31:0] b_base_ff;
   logic [39:0] b_x0_ff;
   logic [63:0] b_xprod;

   always_comb begin
      b_t = 30'(32'(a_az_ff) * 32'd23296 + 32'd18000);
      b_prod = 55'(b_t[29:5]) * 55'(sksol_pkg::RECIP_1125);
      b_xprod = 64'(a_rng_ff) * 64'(sksol_pkg::GAIN);
   end

   always_ff @(posedge clock) begin
      b_u_ff <= b_t[29:5];
      b_q0_ff <= b_prod[54:40];
      b_base_ff <= 32'(a_az_ff) * 32'd119304;
      b_x0_ff <= b_xprod[63:24];
      if (reset) begin
         b_tag_ff.valid <= 1'b0;
      end else begin
         b_tag_ff <= a_tag_ff;
      end
   end

   // Stage C: correct the reciprocal quotient by one.
   sksol_pkg::tag_type c_tag_ff;
   logic [25:0] c_r;
   logic [31:0] c_angle_ff;
   logic [39:0] c_x0_ff;

   assign c_r = 26'(b_u_ff) - 26'(b_q0_ff) * 26'd1125;

   always_ff @(posedge clock) begin
      c_angle_ff <= b_base_ff + 32'(b_q0_ff) + 32'(c_r >= 26'd1125);
      c_x0_ff <= b_x0_ff;
      if (reset) begin
         c_tag_ff.valid <= 1'b0;
      end else begin
         c_tag_ff <= b_tag_ff;
      end
   end

   // Stage D: fold the angle into the right half plane.
   sksol_pkg::cordic_type rot_st [0:N];
   sksol_pkg::tag_type rot_tag [0:N];
   sksol_pkg::cordic_type d_st_ff, d_st_in;
   sksol_pkg::tag_type d_tag_ff, d_tag_in;
   logic signed [sksol_pkg::Z_W-1:0] d_z;

   always_comb begin
      d_z = $signed({{2{c_angle_ff[31]}}, c_angle_ff});
      d_tag_in = c_tag_ff;
      d_st_in.x = sksol_pkg::XY_W'(c_x0_ff);
      d_st_in.y = '0;
      d_st_in.z = d_z;
      if (d_z > $signed(34'sd1073741824)) begin
         d_st_in.z = d_z - $signed(34'sd2147483648);
         d_tag_in.neg = 1'b1;
      end else if (d_z < -$signed(34'sd1073741824)) begin
         d_st_in.z = d_z + $signed(34'sd2147483648);
         d_tag_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      d_st_ff <= d_st_in;
      if (reset) begin
         d_tag_ff.valid <= 1'b0;
      end else begin
         d_tag_ff <= d_tag_in;
      end
   end

   assign rot_st[0] = d_st_ff;
   assign rot_tag[0] = d_tag_ff;

   for (genvar i = 0; i < N; i++) begin : g_rot
      sksol_cordic_cell u_cell (
         .clock(clock), .reset(reset), .vec_mode(1'b0), .shift(5'(i)),
         .atan(sksol_pkg::ATAN_TAB[i]),
         .up_st(rot_st[i]), .up_tag(rot_tag[i]),
         .dn_st(rot_st[i+1]), .dn_tag(rot_tag[i+1])
      );
   end

   // Stage E: station point relative to own ship, in Q.8.
   sksol_pkg::tag_type e_tag_ff;
   logic signed [sksol_pkg::XY_W-1:0] e_north, e_east, e_dn_ff, e_de_ff;

   always_comb begin
      e_north = rot_tag[N].neg ? -rot_st[N].x : rot_st[N].x;
      e_east = rot_tag[N].neg ? -rot_st[N].y : rot_st[N].y;
   end

   always_ff @(posedge clock) begin
      e_dn_ff <= $signed({{7{rot_tag[N].dn_base[32]}}, rot_tag[N].dn_base, 8'h00}) + e_north;
      e_de_ff <= $signed({{7{rot_tag[N].de_base[32]}}, rot_tag[N].de_base, 8'h00}) + e_east;
      if (reset) begin
         e_tag_ff.valid <= 1'b0;
      end else begin
         e_tag_ff <= rot_tag[N];
      end
   end

   // Stage F: bring the vector into the right half plane for vectoring.
   sksol_pkg::cordic_type vec_st [0:N];
   sksol_pkg::tag_type vec_tag [0:N];
   sksol_pkg::cordic_type f_st_ff, f_st_in;
   sksol_pkg::tag_type f_tag_ff;

   always_comb begin
      if (e_dn_ff[sksol_pkg::XY_W-1]) begin
         f_st_in.x = -e_dn_ff;
         f_st_in.y = -e_de_ff;
         f_st_in.z = $signed(34'sd2147483648);
      end else begin
         f_st_in.x = e_dn_ff;
         f_st_in.y = e_de_ff;
         f_st_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      f_st_ff <= f_st_in;
      if (reset) begin
         f_tag_ff.valid <= 1'b0;
      end else begin
         f_tag_ff <= e_tag_ff;
      end
   end

   assign vec_st[0] = f_st_ff;
   assign vec_tag[0] = f_tag_ff;

   for (genvar i = 0; i < N; i++) begin : g_vec
      sksol_cordic_cell u_cell (
         .clock(clock), .reset(reset), .vec_mode(1'b1), .shift(5'(i)),
         .atan(sksol_pkg::ATAN_TAB[i]),
         .up_st(vec_st[i]), .up_tag(vec_tag[i]),
         .dn_st(vec_st[i+1]), .dn_tag(vec_tag[i+1])
      );
   end

   // Stage G: gain correction products and course conversion.
   sksol_pkg::tag_type g_tag_ff;
   logic [46:0] g_ux;
   logic [62:0] g_p1_ff;
   logic [47:0] g_p2;
   logic [31:0] g_p2_ff;
   logic [47:0] g_hprod;
   logic [15:0] g_crs_ff;

   always_comb begin
      g_ux = vec_st[N].x[sksol_pkg::XY_W-1] ? '0 : vec_st[N].x[46:0];
      g_p2 = 48'(g_ux[15:0]) * 48'(sksol_pkg::GAIN);
      g_hprod = 48'(vec_st[N].z[31:0]) * 48'(sksol_pkg::TURN) + 48'h0000_8000_0000;
   end

   always_ff @(posedge clock) begin
      g_p1_ff <= 63'(g_ux[46:16]) * 63'(sksol_pkg::GAIN);
      g_p2_ff <= g_p2[47:16];
      g_crs_ff <= (g_hprod[47:32] == sksol_pkg::TURN) ? 16'd0 : g_hprod[47:32];
      if (reset) begin
         g_tag_ff.valid <= 1'b0;
      end else begin
         g_tag_ff <= vec_tag[N];
      end
   end

   // Stage H: magnitude in Q.8.
   sksol_pkg::tag_type h_tag_ff;
   logic [63:0] h_sum;
   logic [sksol_pkg::MAG_W-1:0] h_mag_ff;
   logic [15:0] h_crs_ff;

   assign h_sum = 64'(g_p1_ff) + 64'(g_p2_ff);

   always_ff @(posedge clock) begin
      h_mag_ff <= h_sum[sksol_pkg::MAG_W+15:16];
      h_crs_ff <= g_crs_ff;
      if (reset) begin
         h_tag_ff.valid <= 1'b0;
      end else begin
         h_tag_ff <= g_tag_ff;
      end
   end

   // Stage I: dividend with rounding, rounded range and on-station test.
   sksol_pkg::dtag_type i_tag_ff, i_tag_in;
   logic [sksol_pkg::NUM_W-1:0] i_num_ff, i_num_in;
   logic [sksol_pkg::MAG_W:0] i_rnd;
   logic [36:0] i_tr;

   always_comb begin
      i_num_in = sksol_pkg::NUM_W'(h_mag_ff)
               * ((h_tag_ff.op == sksol_pkg::OP_DURATION) ? sksol_pkg::NUM_W'(15360)
                                                          : sksol_pkg::NUM_W'(3600))
               + sksol_pkg::NUM_W'(h_tag_ff.given[31:1]);
      i_rnd = (sksol_pkg::MAG_W+1)'(h_mag_ff) + (sksol_pkg::MAG_W+1)'(128);
      i_tr = 37'(i_rnd[sksol_pkg::MAG_W:8]);
      i_tag_in.valid = h_tag_ff.valid;
      i_tag_in.bad = h_tag_ff.bad;
      i_tag_in.onst = (h_mag_ff < sksol_pkg::MAG_W'(256));
      i_tag_in.op = h_tag_ff.op;
      i_tag_in.ovf = 1'b0;
      i_tag_in.ocrs = h_tag_ff.ocrs;
      i_tag_in.crs = h_crs_ff;
      i_tag_in.trange = (i_tr[36:34] != 3'd0) ? '1 : i_tr[33:0];
      i_tag_in.given = h_tag_ff.given;
   end

   always_ff @(posedge clock) begin
      i_num_ff <= i_num_in;
      if (reset) begin
         i_tag_ff.valid <= 1'b0;
      end else begin
         i_tag_ff <= i_tag_in;
      end
   end

   // Stage J: quotient overflow check, then the divider chain.
   sksol_pkg::div_type div_st [0:QW];
   sksol_pkg::dtag_type div_tag [0:QW];
   sksol_pkg::div_type j_div_ff;
   sksol_pkg::dtag_type j_tag_ff, j_tag_in;
   logic [sksol_pkg::CMP_W-1:0] j_lim;

   always_comb begin
      j_lim = (i_tag_ff.op == sksol_pkg::OP_DURATION)
            ? (sksol_pkg::CMP_W'(i_tag_ff.given) << 32)
            : (sksol_pkg::CMP_W'(i_tag_ff.given) << QW);
      j_tag_in = i_tag_ff;
      j_tag_in.ovf = (sksol_pkg::CMP_W'(i_num_ff) >= j_lim);
   end

   always_ff @(posedge clock) begin
      j_div_ff.rem <= i_num_ff;
      j_div_ff.den <= i_tag_ff.given;
      j_div_ff.quo <= '0;
      if (reset) begin
         j_tag_ff.valid <= 1'b0;
      end else begin
         j_tag_ff <= j_tag_in;
      end
   end

   assign div_st[0] = j_div_ff;
   assign div_tag[0] = j_tag_ff;

   for (genvar k = 0; k < QW; k++) begin : g_div
      sksol_div_cell u_cell (
         .clock(clock), .reset(reset), .shift(6'(QW - 1 - k)),
         .up_div(div_st[k]), .up_tag(div_tag[k]),
         .dn_div(div_st[k+1]), .dn_tag(div_tag[k+1])
      );
   end

   // Output stage: pick the case and saturate.
   sksol_pkg::dtag_type o_t;
   logic o_strobe_ff;
   logic [15:0] o_crs_ff, o_crs_in;
   logic [33:0] o_rng_ff, o_rng_in;
   logic [39:0] o_sec_ff, o_sec_in;
   logic [31:0] o_spd_ff, o_spd_in;
   logic o_onst_ff, o_onst_in, o_bad_ff, o_bad_in;
   logic [39:0] o_quo;
   logic [37:0] o_dur;

   always_comb begin
      o_t = div_tag[QW];
      o_quo = div_st[QW].quo;
      o_dur = 38'((38'(o_t.given) * 38'd60 + 38'd128) >> 8);
      o_crs_in = '0;
      o_rng_in = '0;
      o_sec_in = '0;
      o_spd_in = '0;
      o_onst_in = 1'b0;
      o_bad_in = 1'b0;
      priority if (o_t.bad) begin
         o_bad_in = 1'b1;
      end else if (o_t.onst) begin
         o_crs_in = o_t.ocrs;
         o_onst_in = 1'b1;
      end else if (o_t.op == sksol_pkg::OP_DURATION) begin
         o_crs_in = o_t.crs;
         o_rng_in = o_t.trange;
         o_sec_in = 40'(o_dur);
         o_spd_in = o_t.ovf ? '1 : o_quo[31:0];
      end else begin
         o_crs_in = o_t.crs;
         o_rng_in = o_t.trange;
         o_sec_in = o_t.ovf ? '1 : o_quo;
         o_spd_in = o_t.given;
      end
   end

   always_ff @(posedge clock) begin
      o_crs_ff <= o_crs_in;
      o_rng_ff <= o_rng_in;
      o_sec_ff <= o_sec_in;
      o_spd_ff <= o_spd_in;
      o_onst_ff <= o_onst_in;
      o_bad_ff <= o_bad_in;
      if (reset) begin
         o_strobe_ff <= 1'b0;
      end else begin
         o_strobe_ff <= o_t.valid;
      end
   end

   assign rsp_strobe = o_strobe_ff;
   assign rsp_course_to_station = o_crs_ff;
   assign rsp_transit_range = o_rng_ff;
   assign rsp_transit_seconds = o_sec_ff;
   assign rsp_required_speed = o_spd_ff;
   assign rsp_on_station = o_onst_ff;
   assign rsp_bad_value = o_bad_ff;

endmodule

[rtl/sksol_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation of the CORDIC chain, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module sksol_cordic_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 vec_mode,
   input  logic [4:0]           shift,
   input  logic [31:0]          atan,
   input  sksol_pkg::cordic_type up_st,
   input  sksol_pkg::tag_type    up_tag,
   output sksol_pkg::cordic_type dn_st,
   output sksol_pkg::tag_type    dn_tag
);

   sksol_pkg::cordic_type st_ff, st_in;
   sksol_pkg::tag_type tag_ff;
   logic signed [sksol_pkg::XY_W-1:0] dx, dy;
   logic signed [sksol_pkg::Z_W-1:0] za;
   logic cw;

   always_comb begin
      dx = $signed(up_st.y) >>> shift;
      dy = $signed(up_st.x) >>> shift;
      za = $signed({2'b00, atan});
      // Vectoring drives y toward zero, rotation drives z toward zero.
      cw = vec_mode ? ~up_st.y[sksol_pkg::XY_W-1] : up_st.z[sksol_pkg::Z_W-1];
      if (cw) begin
         st_in.x = up_st.x + dx;
         st_in.y = up_st.y - dy;
         st_in.z = up_st.z + za;
      end else begin
         st_in.x = up_st.x - dx;
         st_in.y = up_st.y + dy;
         st_in.z = up_st.z - za;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff <= up_tag;
      end
   end

   assign dn_st = st_ff;
   assign dn_tag = tag_ff;

endmodule

[rtl/sksol_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step that settles one quotient bit.
// ----------------------------------------------------------------------------
module sksol_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [5:0]         shift,
   input  sksol_pkg::div_type  up_div,
   input  sksol_pkg::dtag_type up_tag,
   output sksol_pkg::div_type  dn_div,
   output sksol_pkg::dtag_type dn_tag
);

   sksol_pkg::div_type div_ff, div_in;
   sksol_pkg::dtag_type tag_ff;
   logic [sksol_pkg::CMP_W-1:0] dsh, rem_ext;
   logic ge;

   always_comb begin
      dsh = sksol_pkg::CMP_W'(up_div.den) << shift;
      rem_ext = sksol_pkg::CMP_W'(up_div.rem);
      ge = rem_ext >= dsh;
      div_in.den = up_div.den;
      div_in.rem = ge ? sksol_pkg::NUM_W'(rem_ext - dsh) : up_div.rem;
      div_in.quo = up_div.quo | (sksol_pkg::QUO_W'(ge) << shift);
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff <= up_tag;
      end
   end

   assign dn_div = div_ff;
   assign dn_tag = tag_ff;

endmodule

[test/station_keeping_solution_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station keeping solution core testbench
// Drives directed and random station problems in bursts, predicts each
// solution with a bit-exact fixed-point model and checks every result word.
// ----------------------------------------------------------------------------
module station_keeping_solution_core_tb;

   localparam int N_STEPS = sksol_pkg::CORDIC_STEPS;
   localparam int LATENCY = 2 * N_STEPS + 51;
   localparam logic [63:0] GAIN_K = 64'd2608131496;
   localparam longint TURN_H = 36000;

   typedef struct {
      logic [31:0] own_x;
      logic [31:0] own_y;
      logic [15:0] own_course;
      logic [31:0] guide_x;
      logic [31:0] guide_y;
      logic [15:0] guide_course;
      logic [15:0] rel_bearing;
      logic [31:0] stn_range;
      logic        operation;
      logic [31:0] given;
   } problem_type;

   typedef struct {
      logic [15:0] course;
      logic [33:0] range;
      logic [39:0] seconds;
      logic [31:0] speed;
      logic        on_station;
      logic        bad;
   } solution_type;

   localparam longint ARCTAN [0:31] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_own_x = '0;
   logic [31:0] req_own_y = '0;
   logic [15:0] req_own_course = '0;
   logic [31:0] req_guide_x = '0;
   logic [31:0] req_guide_y = '0;
   logic [15:0] req_guide_course = '0;
   logic [15:0] req_relative_bearing = '0;
   logic [31:0] req_station_range = '0;
   logic        req_operation = 1'b0;
   logic [31:0] req_given_value = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_course_to_station;
   logic [33:0] rsp_transit_range;
   logic [39:0] rsp_transit_seconds;
   logic [31:0] rsp_required_speed;
   logic        rsp_on_station;
   logic        rsp_bad_value;

   problem_type  pending_problems[$];
   solution_type expected_solutions[$];
   int        mismatches = 0;
   int        burst_left = 0;
   int        gap_left = 0;

   station_keeping_solution_core dut (.*);

   always #10 clock = ~clock;

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] hundredths_to_binary(longint h);
      logic [63:0] n;
      n = ((64'(h)) << 32) + 64'd18000;
      return 32'(n / 64'd36000);
   endfunction

   function automatic longint binary_to_hundredths(logic [31:0] b);
      logic [63:0] h;
      h = (64'(b) * 64'd36000 + 64'h8000_0000) >> 32;
      return (h >= 64'd36000) ? 0 : longint'(h);
   endfunction

   function automatic logic [63:0] round_div_sat(logic [63:0] n, logic [63:0] d,
                                                 logic [63:0] maxv);
      logic [63:0] q;
      q = (n + d / 2) / d;
      return (q > maxv) ? maxv : q;
   endfunction

   function automatic solution_type solve_station(problem_type p);
      solution_type s;
      longint ox, oy, gx, gy, ocrs, gcrs, rel, az;
      longint x, y, z, dx, dy, north, east;
      logic [31:0] ang;
      logic [63:0] ux, full, mag, r;
      bit flip;
      ox = longint'(signed'(p.own_x));
      oy = longint'(signed'(p.own_y));
      gx = longint'(signed'(p.guide_x));
      gy = longint'(signed'(p.guide_y));
      ocrs = longint'(p.own_course) % TURN_H;
      gcrs = longint'(p.guide_course) % TURN_H;
      rel = longint'(p.rel_bearing) % TURN_H;
      s = '{default: '0};
      if (p.given == 0) begin
         s.bad = 1'b1;
         return s;
      end
      az = (gcrs + rel) % TURN_H;
      ang = hundredths_to_binary(az);
      // Rotate the gain-scaled range to the station bearing.
      r = 64'(p.stn_range);
      x = longint'((r * GAIN_K) >> 24);
      y = 0;
      z = longint'(signed'(ang));
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < N_STEPS; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      north = flip ? -x : x;
      east = flip ? -y : y;
      // Vector from own ship to the station point, back to polar.
      x = gy * 256 + north - oy * 256;
      y = gx * 256 + east - ox * 256;
      z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = 64'sd2147483648;
      end
      for (int i = 0; i < N_STEPS; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += ARCTAN[i];
         end else begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end
      end
      ang = 32'(z);
      ux = (x < 0) ? 64'd0 : 64'(x);
      full = (ux >> 16) * GAIN_K + (((ux & 64'hFFFF) * GAIN_K) >> 16);
      mag = full >> 16;
      if (mag < 256) begin
         s.course = 16'(ocrs);
         s.on_station = 1'b1;
         return s;
      end
      s.course = 16'(binary_to_hundredths(ang));
      s.range = 34'(round_div_sat(mag, 64'd256, 64'h3_FFFF_FFFF));
      if (p.operation == sksol_pkg::OP_DURATION) begin
         s.seconds = 40'((64'(p.given) * 64'd60 + 64'd128) >> 8);
         s.speed = 32'(round_div_sat(mag * 64'd15360, 64'(p.given), 64'hFFFF_FFFF));
      end else begin
         s.seconds = 40'(round_div_sat(mag * 64'd3600, 64'(p.given),
                                       64'hFF_FFFF_FFFF));
         s.speed = p.given;
      end
      return s;
   endfunction

   function automatic logic [31:0] random_position();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   function automatic logic [15:0] random_angle();
      return ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
   endfunction

   task automatic queue_problem(problem_type p);
      pending_problems.push_back(p);
   endtask

   // Driver: bursts of words separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_solutions.push_back(solve_station('{req_own_x, req_own_y,
               req_own_course, req_guide_x, req_guide_y, req_guide_course,
               req_relative_bearing, req_station_range, req_operation,
               req_given_value}));
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_problems.size() > 0) begin
               problem_type p;
               p = pending_problems.pop_front();
               start <= 1'b1;
               req_own_x <= p.own_x;
               req_own_y <= p.own_y;
               req_own_course <= p.own_course;
               req_guide_x <= p.guide_x;
               req_guide_y <= p.guide_y;
               req_guide_course <= p.guide_course;
               req_relative_bearing <= p.rel_bearing;
               req_station_range <= p.stn_range;
               req_operation <= p.operation;
               req_given_value <= p.given;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed word is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_solutions.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("Unexpected result word at %0t", $realtime);
         end else begin
            solution_type e;
            e = expected_solutions.pop_front();
            if (e.course !== rsp_course_to_station || e.range !== rsp_transit_range ||
                e.seconds !== rsp_transit_seconds || e.speed !== rsp_required_speed ||
                e.on_station !== rsp_on_station || e.bad !== rsp_bad_value) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("Mismatch: exp crs %0d rng %0d sec %0d spd %0d on %0b bad %0b",
                     e.course, e.range, e.seconds, e.speed, e.on_station, e.bad,
                     " / got crs %0d rng %0d sec %0d spd %0d on %0b bad %0b",
                     rsp_course_to_station, rsp_transit_range, rsp_transit_seconds,
                     rsp_required_speed, rsp_on_station, rsp_bad_value);
            end
         end
      end
   end

   initial begin
      problem_type p;
      // Directed: extremes, both operations, zero given value, on station,
      // and out-of-range angles.
      p = '{32'h0, 32'h0, 16'd0, 32'h0, 32'h0, 16'd0, 16'd0, 32'h0, 1'b0, 32'h10000};
      queue_problem(p);
      p.given = 32'h0; queue_problem(p);
      p.operation = 1'b1; queue_problem(p);
      p = '{32'h0, 32'h0, 16'd12345, 32'h0, 32'h0, 16'd9000, 16'd4500,
            32'h0, 1'b1, 32'h10000};
      queue_problem(p);
      p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd35999, 32'h8000_0000, 32'h8000_0000,
            16'd35999, 16'd35999, 32'hFFFF_FFFF, 1'b0, 32'd1};
      queue_problem(p);
      p.operation = 1'b1; queue_problem(p);
      p.given = 32'hFFFF_FFFF; queue_problem(p);
      p.operation = 1'b0; queue_problem(p);
      p = '{32'h8000_0000, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd1};
      queue_problem(p);
      p = '{32'h0, 32'h0, 16'd36000, 32'h0, 32'h0, 16'd27000, 16'd18000,
            32'h0005_0000, 1'b0, 32'h000A_0000};
      queue_problem(p);
      for (int b = 0; b < 8; b++) begin
         p = '{32'h0001_0000, 32'hFFFF_0000, 16'd100, 32'h0, 32'h0, 16'(b * 4500),
               16'd0, 32'h0003_0000, b[0], 32'h0001_8000};
         queue_problem(p);
      end
      p = '{32'h0, 32'h0, 16'd500, 32'h0, 32'h0, 16'd0, 16'd0, 32'd1, 1'b0, 32'd7};
      queue_problem(p);
      p.stn_range = 32'd0; p.own_x = 32'd1; queue_problem(p);
      for (int i = 0; i < 450; i++) begin
         p.own_x = random_position();
         p.own_y = random_position();
         p.own_course = random_angle();
         p.guide_course = random_angle();
         p.rel_bearing = random_angle();
         p.operation = 1'($urandom_range(0, 1));
         p.stn_range = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000);
         if ($urandom_range(0, 9) == 0) begin
            // Place the guide so the station point lands on own ship.
            p.stn_range = 32'd0;
            p.guide_x = p.own_x;
            p.guide_y = p.own_y;
         end else begin
            p.guide_x = random_position();
            p.guide_y = random_position();
         end
         case ($urandom_range(0, 9))
            0: p.given = 32'd0;
            1: p.given = $urandom_range(1, 255);
            2, 3: p.given = $urandom;
            default: p.given = $urandom_range(32'h100, 32'h0100_0000);
         endcase
         queue_problem(p);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_problems.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      while (expected_solutions.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_solutions.size() == 0)
         $display("station_keeping_solution_core test passed");
      else
         $display("station_keeping_solution_core test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("station_keeping_solution_core test failed");
      $finish;
   end

endmodule
